// File: rtl/core/npd_pkg.sv
// Package for the nibble packet deframer.
// Holds the direction codes, header constants and the result record type.
// No dependencies.
`default_nettype none

package npd_pkg;

  // Direction codes carried in bits 6:5 of packet byte 1.
  localparam logic [1:0] DIR_SEND    = 2'd0;
  localparam logic [1:0] DIR_REQUEST = 2'd1;
  localparam logic [1:0] DIR_REPLY   = 2'd2;
  localparam logic [1:0] DIR_UNUSED  = 2'd3;

  // Byte positions inside a packet that carry header bits.
  localparam logic [5:0] POS_TYPE   = 6'd1;
  localparam logic [5:0] POS_LENGTH = 6'd2;

  // One result beat as it sits in the output registers.
  typedef struct packed {
    logic [6:0]  command_id;
    logic [1:0]  direction;
    logic        word_is_short;
    logic [3:0]  packet_length;
    logic [2:0]  word_index;
    logic [15:0] word_value;
    logic        has_word;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/nibble_packet_deframer.sv
// Nibble packet deframer top level.
// Parses received bytes into packet headers and data words; uses npd_pkg.
`default_nettype none

// The block takes one received byte per beat and can take a byte in every
// cycle. While hunting it drops bytes with bit 7 clear; a byte with bit 7
// set opens a packet and gives the command id in its low seven bits. Byte 1
// holds direction and word type, byte 2 holds length minus one, and every
// byte from byte 1 on carries one data nibble, low nibble first. Send and
// reply packets give one result beat per finished word; a request packet
// gives one beat after byte 2, and an unused-direction packet gives one beat
// after its final byte. A result is registered in the output register, or in
// the skid register while the output holds a stalled beat. A two-entry
// output buffer (output register plus skid register) lets input keep flowing
// while the output stalls until a second result beat has to wait; the input
// stalls only while the skid register is full.
module nibble_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       command_id,
  output logic [1:0]       direction,
  output logic             word_is_short,
  output logic [3:0]       packet_length,
  output logic [2:0]       word_index,
  output logic [15:0]      word_value,
  output logic             has_word,
  output logic             last
);
  import npd_pkg::*;

  typedef enum logic {PH_HUNT, PH_BODY} phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  held_command, held_command_next;
  logic [1:0]  held_direction, held_direction_next;
  logic        held_type, held_type_next;
  logic [3:0]  held_length, held_length_next;
  logic [5:0]  byte_position, byte_position_next;
  logic [11:0] nibble_gather, nibble_gather_next;

  logic        res_valid;
  result_t     res;
  result_t     out_reg, skid;
  logic        skid_valid;
  logic        in_accept, out_take;

  logic [3:0]  nib;
  logic [5:0]  pm1;
  logic [1:0]  slot;
  logic        final_slot;
  logic [4:0]  word;
  logic        is_last;
  logic [15:0] value;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;
  assign nib       = rx_byte[3:0];

  // Word slot arithmetic on the current byte position.
  always_comb begin
    pm1        = byte_position - 6'd1;
    slot       = held_type_next ? pm1[1:0] : {1'b0, pm1[0]};
    final_slot = held_type_next ? (slot == 2'd3) : (slot == 2'd1);
    word       = held_type_next ? {1'b0, pm1[5:2]} : pm1[5:1];
    is_last    = ({1'b0, word} + 6'd1) >= {2'b00, held_length_next};
    value      = held_type_next ? {nib, nibble_gather}
                                : {8'd0, nib, nibble_gather[3:0]};
  end

  // Header fields as updated by this byte.
  always_comb begin
    held_command_next   = held_command;
    held_direction_next = held_direction;
    held_type_next      = held_type;
    held_length_next    = held_length;
    if (phase == PH_HUNT) begin
      if (rx_byte[7]) begin
        held_command_next = rx_byte[6:0];
      end
    end else if (byte_position == POS_TYPE) begin
      held_direction_next = rx_byte[6:5];
      held_type_next      = rx_byte[4];
    end else if (byte_position == POS_LENGTH) begin
      held_length_next = {1'b0, rx_byte[6:4]} + 4'd1;
    end
  end

  // Packet sequencing and result formation.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    nibble_gather_next = nibble_gather;
    res_valid          = 1'b0;
    res.command_id     = held_command_next;
    res.direction      = held_direction_next;
    res.word_is_short  = held_type_next;
    res.packet_length  = held_length_next;
    res.word_index     = 3'd0;
    res.word_value     = 16'd0;
    res.has_word       = 1'b0;
    res.last           = 1'b1;
    if (phase == PH_HUNT) begin
      if (rx_byte[7]) begin
        phase_next         = PH_BODY;
        byte_position_next = 6'd1;
        nibble_gather_next = 12'd0;
      end
    end else if (held_direction_next == DIR_REQUEST) begin
      // A request packet ends after its length byte.
      if (byte_position >= POS_LENGTH) begin
        res_valid          = 1'b1;
        phase_next         = PH_HUNT;
        byte_position_next = 6'd0;
        nibble_gather_next = 12'd0;
      end else begin
        byte_position_next = byte_position + 6'd1;
      end
    end else if (!final_slot) begin
      // Collect a nibble of the word being built.
      case (slot)
        2'd0:    nibble_gather_next = nibble_gather | {8'd0, nib};
        2'd1:    nibble_gather_next = nibble_gather | {4'd0, nib, 4'd0};
        default: nibble_gather_next = nibble_gather | {nib, 8'd0};
      endcase
      byte_position_next = byte_position + 6'd1;
    end else begin
      // The word is complete.
      if (held_direction_next == DIR_UNUSED) begin
        res_valid = is_last;
      end else begin
        res_valid      = 1'b1;
        res.word_index = word[2:0];
        res.word_value = value;
        res.has_word   = 1'b1;
        res.last       = is_last;
      end
      nibble_gather_next = 12'd0;
      if (is_last) begin
        phase_next         = PH_HUNT;
        byte_position_next = 6'd0;
      end else begin
        byte_position_next = byte_position + 6'd1;
      end
    end
  end

  // Parser state, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      held_command   <= 7'd0;
      held_direction <= DIR_SEND;
      held_type      <= 1'b0;
      held_length    <= 4'd1;
      byte_position  <= 6'd0;
      nibble_gather  <= 12'd0;
    end else if (in_accept) begin
      phase          <= phase_next;
      held_command   <= held_command_next;
      held_direction <= held_direction_next;
      held_type      <= held_type_next;
      held_length    <= held_length_next;
      byte_position  <= byte_position_next;
      nibble_gather  <= nibble_gather_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take || !out_valid) begin
        out_reg    <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (out_take || !out_valid) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign command_id    = out_reg.command_id;
  assign direction     = out_reg.direction;
  assign word_is_short = out_reg.word_is_short;
  assign packet_length = out_reg.packet_length;
  assign word_index    = out_reg.word_index;
  assign word_value    = out_reg.word_value;
  assign has_word      = out_reg.has_word;
  assign last          = out_reg.last;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for nibble_packet_deframer: directed packets, then random
// packets and noise bytes; each result beat is checked against a typed beat or a local
// parser model. Depends on npd_pkg and the nibble_packet_deframer RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import npd_pkg::*;

  localparam int RANDOM_BYTES = 700;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_LIMIT  = 5000;

  typedef enum logic {HUNTING, IN_PACKET} parse_phase_t;

  // One row of the directed stimulus; the expected beat is typed in only for
  // rows whose result is obvious, the rest go through the parser model.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } directed_row_t;

  localparam result_t NO_RESULT = '0;

  // Request packet with the largest command id and length field.
  localparam result_t REQ_MAX = '{command_id: 7'd127, direction: DIR_REQUEST,
                                  word_is_short: 1'b0, packet_length: 4'd8,
                                  word_index: 3'd0, word_value: 16'h0000,
                                  has_word: 1'b0, last: 1'b1};
  // Send packet with command id zero and one eight-bit word.
  localparam result_t SEND_MIN = '{command_id: 7'd0, direction: DIR_SEND,
                                   word_is_short: 1'b0, packet_length: 4'd1,
                                   word_index: 3'd0, word_value: 16'h00A5,
                                   has_word: 1'b1, last: 1'b1};
  // Unused-direction packet: one empty beat after its final byte.
  localparam result_t UNUSED_ONE = '{command_id: 7'd1, direction: DIR_UNUSED,
                                     word_is_short: 1'b1, packet_length: 4'd1,
                                     word_index: 3'd0, word_value: 16'h0000,
                                     has_word: 1'b0, last: 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  command_id;
  logic [1:0]  direction;
  logic        word_is_short;
  logic [3:0]  packet_length;
  logic [2:0]  word_index;
  logic [15:0] word_value;
  logic        has_word;
  logic        last;

  // Parser model state.
  parse_phase_t rx_phase   = HUNTING;
  logic [6:0]   pkt_cmd    = '0;
  logic [1:0]   pkt_dir    = DIR_SEND;
  logic         pkt_short  = 1'b0;
  logic [3:0]   pkt_len    = 4'd1;
  logic [5:0]   pkt_pos    = '0;
  logic [11:0]  pkt_gather = '0;

  result_t       results_due [$];
  directed_row_t directed_rows [0:21];
  int            error_count = 0;
  int            burst_left = 0;
  bit            long_hold_pending = 1'b0;

  nibble_packet_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command_id    (command_id),
    .direction     (direction),
    .word_is_short (word_is_short),
    .packet_length (packet_length),
    .word_index    (word_index),
    .word_value    (word_value),
    .has_word      (has_word),
    .last          (last)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous backstop on the whole run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic result_t packet_beat(input logic [2:0] idx, input logic [15:0] value,
                                          input logic has, input logic fin);
    result_t r;
    r.command_id    = pkt_cmd;
    r.direction     = pkt_dir;
    r.word_is_short = pkt_short;
    r.packet_length = pkt_len;
    r.word_index    = idx;
    r.word_value    = value;
    r.has_word      = has;
    r.last          = fin;
    return r;
  endfunction

  function automatic void return_to_hunt();
    rx_phase   = HUNTING;
    pkt_pos    = '0;
    pkt_gather = '0;
  endfunction

  // Parses one accepted byte; returns 1 when the byte completes a result beat.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t beat);
    logic [5:0]  p;
    int          per;
    int          slot;
    int          word;
    logic [15:0] value;
    bit          fin;
    beat = NO_RESULT;
    if (rx_phase == HUNTING) begin
      if (b[7]) begin
        pkt_cmd    = b[6:0];
        rx_phase   = IN_PACKET;
        pkt_pos    = 6'd1;
        pkt_gather = '0;
      end
      return 1'b0;
    end
    p = pkt_pos;
    if (p == POS_TYPE) begin
      pkt_dir   = b[6:5];
      pkt_short = b[4];
    end else if (p == POS_LENGTH) begin
      pkt_len = {1'b0, b[6:4]} + 4'd1;
    end
    // A request packet ends with its length byte.
    if (pkt_dir == DIR_REQUEST) begin
      if (p >= POS_LENGTH) begin
        beat = packet_beat(3'd0, 16'h0000, 1'b0, 1'b1);
        return_to_hunt();
        return 1'b1;
      end
      pkt_pos = p + 6'd1;
      return 1'b0;
    end
    // Gather nibbles, low nibble first, until the word is complete.
    per   = pkt_short ? 4 : 2;
    slot  = (int'(p) - 1) & (per - 1);
    word  = (int'(p) - 1) / per;
    value = {4'd0, pkt_gather} | ({12'd0, b[3:0]} << (4 * slot));
    if (slot != per - 1) begin
      pkt_gather = value[11:0];
      pkt_pos    = p + 6'd1;
      return 1'b0;
    end
    fin = (word + 1 >= int'(pkt_len));
    pkt_gather = '0;
    if (pkt_dir == DIR_UNUSED) begin
      if (fin) begin
        beat = packet_beat(3'd0, 16'h0000, 1'b0, 1'b1);
      end
    end else begin
      beat = packet_beat(word[2:0], value, 1'b1, fin);
    end
    if (fin) begin
      return_to_hunt();
    end else begin
      pkt_pos = p + 6'd1;
    end
    return (pkt_dir != DIR_UNUSED) || fin;
  endfunction

  // Offers one byte, with bursts and gaps on the sender side, and records
  // the expected beat once the byte is taken.
  task automatic send_rx(input logic [7:0] b, input logic typed, input result_t want);
    int      gap;
    bit      produced;
    result_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    rx_byte  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    produced = deframe_byte(b, predicted);
    if (typed) begin
      results_due.push_back(want);
    end else if (produced) begin
      results_due.push_back(predicted);
    end
  endtask

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin
    int   mode;
    int   span;
    logic hold;
    hold = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 48);
      repeat (span) begin
        if (long_hold_pending) begin
          long_hold_pending = 1'b0;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          0: hold = 1'b0;
          1: hold = ($urandom_range(0, 9) < 3);
          2: hold = ($urandom_range(0, 9) < 7);
          default: hold = ~hold;
        endcase
        out_stall <= hold;
        @(posedge clk);
      end
    end
  end

  // Result checker: each beat taken is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t due;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected: cmd %0h value %0h",
                                  command_id, word_value));
      end else begin
        due = results_due.pop_front();
        check_field("command_id", 16'(command_id), 16'(due.command_id));
        check_field("direction", 16'(direction), 16'(due.direction));
        check_field("word_is_short", 16'(word_is_short), 16'(due.word_is_short));
        check_field("packet_length", 16'(packet_length), 16'(due.packet_length));
        check_field("word_index", 16'(word_index), 16'(due.word_index));
        check_field("word_value", word_value, due.word_value);
        check_field("has_word", 16'(has_word), 16'(due.has_word));
        check_field("last", 16'(last), 16'(due.last));
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int         sent;
    int         pick;
    int         nbytes;
    int         drain_cycles;
    bit         hold_done;
    bit         pause_done;
    logic [6:0] cmd;
    logic [1:0] dir;
    logic       shortw;
    logic [3:0] len;
    logic [2:0] len_field;
    logic [7:0] b;

    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // Directed packets: dropped noise, request with extreme header, minimal
    // send, reply with start bits inside the body, unused direction.
    directed_rows = '{
      '{8'h00, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT}, '{8'h2F, 1'b0, NO_RESULT}, '{8'h70, 1'b1, REQ_MAX},
      '{8'h80, 1'b0, NO_RESULT}, '{8'h05, 1'b0, NO_RESULT}, '{8'h0A, 1'b1, SEND_MIN},
      '{8'h85, 1'b0, NO_RESULT}, '{8'h51, 1'b0, NO_RESULT}, '{8'h12, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT}, '{8'h04, 1'b0, NO_RESULT}, '{8'h8F, 1'b0, NO_RESULT},
      '{8'h8E, 1'b0, NO_RESULT}, '{8'h8D, 1'b0, NO_RESULT}, '{8'h8C, 1'b0, NO_RESULT},
      '{8'h81, 1'b0, NO_RESULT}, '{8'h70, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b1, UNUSED_ONE}
    };

    // Reset.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_rx(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: mostly well-formed packets, some noise and stray bytes.
    while (sent < RANDOM_BYTES) begin
      if (!hold_done && sent >= 200) begin
        hold_done = 1'b1;
        long_hold_pending = 1'b1;
      end
      if (!pause_done && sent >= 450) begin
        // Sender waits until every expected beat has come out.
        pause_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_rx({1'b0, 7'($urandom_range(0, 127))}, 1'b0, '0);
      end else if (pick < 14) begin
        repeat ($urandom_range(1, 6)) begin
          send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
          sent++;
        end
      end else begin
        cmd    = 7'($urandom_range(0, 127));
        dir    = 2'($urandom_range(0, 3));
        shortw = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 99);
        len    = (pick < 70) ? 4'($urandom_range(1, 3)) :
                 (pick < 90) ? 4'($urandom_range(4, 7)) : 4'd8;
        len_field = 3'(len - 4'd1);
        nbytes = (dir == DIR_REQUEST) ? 3 : (shortw ? 4 : 2) * int'(len) + 1;
        send_rx({1'b1, cmd}, 1'b0, '0);
        for (int i = 1; i < nbytes; i++) begin
          b = 8'($urandom_range(0, 255));
          if (i == 1) begin
            b[6:4] = {dir, shortw};
          end else if (i == 2) begin
            b[6:4] = len_field;
          end
          send_rx(b, 1'b0, '0);
        end
        sent += nbytes;
      end
    end
    in_valid <= 1'b0;

    // Drain the remaining beats, then allow the output latency to pass.
    drain_cycles = 0;
    while (results_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", results_due.size()));
    end
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
